// ===== design/integer_to_ascii_radix_top_defines.svh =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_top_defines
// assertion macros shared by the radix text converter
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_TOP_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_TOP_DEFINES_SVH

// same-cycle implication
`define I2A_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("i2a check failed");

// next-cycle implication
`define I2A_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("i2a check failed");

`endif

// ===== design/i2a_pkg.sv =====
// ----------------------------------------------------------------------------
// i2a_pkg
// constants, reciprocal table and digit encoding for the radix text converter
// ----------------------------------------------------------------------------
`default_nettype none

package i2a_pkg;

    localparam int VALUE_W = 32;
    localparam int BASE_W  = 6;
    localparam int CHAR_W  = 8;
    localparam int PROD_W  = 2 * VALUE_W;
    // estimated remainder stays below twice the largest base
    localparam int REM_W   = 7;

    localparam logic [BASE_W-1:0] MIN_BASE       = 6'd2;
    localparam logic [BASE_W-1:0] MAX_BASE       = 6'd36;
    localparam logic [BASE_W-1:0] DECIMAL_DIGITS = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;

    localparam longint unsigned RECIP_ONE = 64'h1_0000_0000;

    // floor(2^32 / base), zero for bases out of range
    localparam logic [VALUE_W-1:0] RECIP_TABLE [2**BASE_W] = '{
        2:  32'(RECIP_ONE / 2),  3:  32'(RECIP_ONE / 3),  4:  32'(RECIP_ONE / 4),
        5:  32'(RECIP_ONE / 5),  6:  32'(RECIP_ONE / 6),  7:  32'(RECIP_ONE / 7),
        8:  32'(RECIP_ONE / 8),  9:  32'(RECIP_ONE / 9),  10: 32'(RECIP_ONE / 10),
        11: 32'(RECIP_ONE / 11), 12: 32'(RECIP_ONE / 12), 13: 32'(RECIP_ONE / 13),
        14: 32'(RECIP_ONE / 14), 15: 32'(RECIP_ONE / 15), 16: 32'(RECIP_ONE / 16),
        17: 32'(RECIP_ONE / 17), 18: 32'(RECIP_ONE / 18), 19: 32'(RECIP_ONE / 19),
        20: 32'(RECIP_ONE / 20), 21: 32'(RECIP_ONE / 21), 22: 32'(RECIP_ONE / 22),
        23: 32'(RECIP_ONE / 23), 24: 32'(RECIP_ONE / 24), 25: 32'(RECIP_ONE / 25),
        26: 32'(RECIP_ONE / 26), 27: 32'(RECIP_ONE / 27), 28: 32'(RECIP_ONE / 28),
        29: 32'(RECIP_ONE / 29), 30: 32'(RECIP_ONE / 30), 31: 32'(RECIP_ONE / 31),
        32: 32'(RECIP_ONE / 32), 33: 32'(RECIP_ONE / 33), 34: 32'(RECIP_ONE / 34),
        35: 32'(RECIP_ONE / 35), 36: 32'(RECIP_ONE / 36),
        default: 32'd0
    };

    function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
        if (d < DECIMAL_DIGITS) begin
            return CHAR_ZERO + CHAR_W'(d);
        end
        return CHAR_LOWER_A + CHAR_W'(d) - CHAR_W'(DECIMAL_DIGITS);
    endfunction

endpackage

`default_nettype wire

// ===== design/i2a_ram.sv =====
// ----------------------------------------------------------------------------
// i2a_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module i2a_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/integer_to_ascii_radix_top.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_top
// converts an unsigned number to ascii text in a base from 2 to 36
// ----------------------------------------------------------------------------
// One input beat carries a value and a base; the block answers with one beat
// per character, most significant digit first, tlast on the final one. Each
// digit passes through a shared divide unit: a 32x32 multiply by the
// reciprocal of the base from a constant table, then a remainder correction
// that writes the digit into a small ram. Characters then leave one per cycle
// while the output is not stalled, after a ram read state. A base outside
// 2..36 yields a single beat with tuser set and tdata zero, valid once the
// error state finds the output free. s_tready is high only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_to_ascii_radix_top_defines.svh"

module integer_to_ascii_radix_top #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // value [31:0], base [37:32], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // char_code [7:0]
    output logic             m_tlast,
    output logic [0:0]       m_tuser    // bad_base [0]
);

    localparam int QW = (VALUE_BITS < i2a_pkg::VALUE_W) ? VALUE_BITS : i2a_pkg::VALUE_W;
    localparam int CW = $clog2(VALUE_BITS + 1);
    localparam int AW = $clog2(VALUE_BITS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_CORR = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;
    localparam logic [2:0] ST_ERR  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [QW-1:0] quot_reg, quot_next;
    logic [i2a_pkg::BASE_W-1:0] base_reg, base_next;
    logic [i2a_pkg::PROD_W-1:0] prod_reg, prod_next;

    logic m_valid_reg, m_valid_next;
    logic [i2a_pkg::CHAR_W-1:0] m_char_reg, m_char_next;
    logic m_last_reg, m_last_next;
    logic m_bad_reg, m_bad_next;

    logic [i2a_pkg::VALUE_W-1:0] s_value;
    logic [i2a_pkg::BASE_W-1:0] s_base;
    logic base_ok;
    logic out_free;

    logic [QW-1:0] q_est;
    logic [i2a_pkg::REM_W-1:0] qb_low;
    logic [i2a_pkg::REM_W-1:0] r_est;
    logic [i2a_pkg::REM_W-1:0] base_wide;
    logic [i2a_pkg::REM_W-1:0] rem;
    logic fix;
    logic done;

    logic ram_we;
    logic ram_re;
    logic [AW-1:0] ram_raddr;
    logic [i2a_pkg::CHAR_W-1:0] ram_wdata;
    logic [i2a_pkg::CHAR_W-1:0] ram_rdata;

    assign s_value = s_tdata[i2a_pkg::VALUE_W-1:0];
    assign s_base  = s_tdata[i2a_pkg::VALUE_W +: i2a_pkg::BASE_W];
    assign base_ok = s_base inside {[i2a_pkg::MIN_BASE:i2a_pkg::MAX_BASE]};

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_char_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_bad_reg;

    assign out_free = !m_valid_reg || m_tready;

    // remainder correction after the reciprocal multiply
    assign q_est     = QW'(prod_reg[i2a_pkg::PROD_W-1 -: i2a_pkg::VALUE_W]);
    assign base_wide = i2a_pkg::REM_W'(base_reg);
    assign qb_low    = q_est[i2a_pkg::REM_W-1:0] * base_wide;
    assign r_est     = quot_reg[i2a_pkg::REM_W-1:0] - qb_low;
    assign fix       = (r_est >= base_wide);
    assign rem       = fix ? (r_est - base_wide) : r_est;
    assign done      = ((q_est == '0) && !fix) || (cnt_reg == CW'(VALUE_BITS - 1));

    assign ram_we    = (state_reg == ST_CORR);
    assign ram_wdata = i2a_pkg::digit_char(rem[i2a_pkg::BASE_W-1:0]);
    assign ram_re    = (state_reg == ST_RD)
                     || ((state_reg == ST_EMIT) && out_free && (idx_reg != '0));
    assign ram_raddr = (state_reg == ST_EMIT) ? (idx_reg - AW'(1)) : idx_reg;

    i2a_ram #(
        .WIDTH (i2a_pkg::CHAR_W),
        .DEPTH (VALUE_BITS)
    ) u_digit_store (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        quot_next    = quot_reg;
        base_next    = base_reg;
        prod_next    = prod_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_char_next  = m_char_reg;
        m_last_next  = m_last_reg;
        m_bad_next   = m_bad_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    quot_next = s_value[QW-1:0];
                    base_next = s_base;
                    cnt_next  = '0;
                    state_next = base_ok ? ST_MUL : ST_ERR;
                end
            end
            ST_MUL: begin
                prod_next = i2a_pkg::PROD_W'(i2a_pkg::VALUE_W'(quot_reg))
                          * i2a_pkg::PROD_W'(i2a_pkg::RECIP_TABLE[base_reg]);
                state_next = ST_CORR;
            end
            ST_CORR: begin
                cnt_next  = cnt_reg + CW'(1);
                quot_next = q_est + QW'(fix);
                if (done) begin
                    idx_next   = cnt_reg[AW-1:0];
                    state_next = ST_RD;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_RD: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = ram_rdata;
                    m_last_next  = (idx_reg == '0);
                    m_bad_next   = 1'b0;
                    if (idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg - AW'(1);
                    end
                end
            end
            ST_ERR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_char_next  = '0;
                    m_last_next  = 1'b1;
                    m_bad_next   = 1'b1;
                    quot_next    = '0;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        quot_reg   <= quot_next;
        base_reg   <= base_next;
        prod_reg   <= prod_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
        m_bad_reg  <= m_bad_next;
    end

    `I2A_ASSERT_NOW(a_bad_beat_form, aclk, aresetn, m_valid_reg && m_bad_reg, m_last_reg && (m_char_reg == '0))
    `I2A_ASSERT_NOW(a_rem_below_base, aclk, aresetn, state_reg == ST_CORR, rem < base_wide)
    `I2A_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `I2A_ASSERT_NOW(a_count_in_range, aclk, aresetn, state_reg != ST_IDLE, cnt_reg <= CW'(VALUE_BITS))

endmodule

`default_nettype wire
